>>> hw/rtl/ufq_pkg.sv
// Shared types, constants and helpers for the form query decoder.
package ufq_pkg;

	// Width that bounds the pair counter; the pair limit is capped at 2^IndexBits - 1.
	localparam int IndexBits = 16;
	localparam logic [15:0] IndexCap = (IndexBits >= 16) ? 16'hffff
		: 16'((32'd1 << IndexBits) - 32'd1);

	// Result kinds
	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// Configuration register indexes
	localparam logic [3:0] CFG_FILTER_ENABLE = 4'd0;
	localparam logic [3:0] CFG_MAX_PAIRS     = 4'd1;

	localparam logic [15:0] MAX_PAIRS_RESET = 16'd1023;

	// Characters
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} ufq_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] pair_index;
		logic        bad_escape;
		logic        overflow;
		logic        run_last;
	} ufq_out_t;

	// One or two results produced by a single input byte
	typedef struct packed {
		logic [1:0] count;
		ufq_out_t   first;
		ufq_out_t   second;
	} ufq_burst_t;

	// Loose hex digit value: letters folded to upper case, signed compare against 'A'
	function automatic logic [7:0] hex_val(input logic [7:0] b);
		logic [7:0] r;
		if (b >= 8'h41 && b < 8'h80) begin
			r = (b & 8'hdf) - 8'd55;
		end else begin
			r = b - 8'd48;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/url_form_query_decoder.sv
// Top level of the streaming form-urlencoded query decoder.
//
// Input channel (in_valid/in_ready/in_data) takes one raw query byte per transfer,
// with in_last on the final byte of a buffer. Each byte yields one or two results
// on the output channel (out_valid/out_ready/out_data): a name or value byte, a
// pair end, or a silent kind-3 marker; run_last flags the last result of a byte.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
// filter_enable (index 0) and max_pairs (index 1); cfg_ready is always high and
// writes belong between buffers while the block is idle.
// An accepted byte is held in the byte register, then its results go into the queue.
// Throughput: one byte per cycle while out_ready is high and each byte makes one
// result; a byte that makes two results (data plus closing pair end) holds the
// single output port for both. The byte register feeds the decode logic, whose
// results land in a three-entry queue; a new byte is taken whenever the queue
// has room for a full burst, so a waiting result does not stop intake.
// Reset clears the stream state, the queue and loads the register defaults.
// When the receiver stalls, results collect in the queue, then the byte
// register holds and in_ready drops; nothing is lost.
module url_form_query_decoder import ufq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ufq_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output ufq_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        filter_q;
	logic [15:0] max_pairs_q;
	logic        valid_s1;
	ufq_in_t     item_s1;
	logic        space, advance;
	ufq_burst_t  burst;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && space;
	assign in_ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= 1'b0;
			max_pairs_q <= MAX_PAIRS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FILTER_ENABLE: filter_q <= cfg_data[0];
				CFG_MAX_PAIRS:     max_pairs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	ufq_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item_s1),
		.filter_enable(filter_q),
		.max_pairs    (max_pairs_q),
		.burst        (burst)
	);

	ufq_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.burst    (burst),
		.space    (space),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

>>> hw/rtl/ufq_decode.sv
// Per-byte decode logic and running stream state of the form query decoder.
module ufq_decode import ufq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  ufq_in_t     item,
	input  logic        filter_enable,
	input  logic [15:0] max_pairs,
	output ufq_burst_t  burst
);

	typedef enum logic [1:0] {ESC_NONE, ESC_HIGH, ESC_LOW} esc_t;

	logic        in_value_q, in_value_n;
	esc_t        esc_q, esc_n;
	logic [7:0]  hi_q, hi_n;
	logic        open_q, open_n;
	logic [15:0] count_q, count_n;

	logic [15:0] limit;
	logic [7:0]  b, bp, hv, d;
	logic        keep, dropped, have, have_r0, end_valid;
	ufq_out_t    r0, r_end, r_none;

	assign limit = (max_pairs < IndexCap) ? max_pairs : IndexCap;

	always_comb begin
		b = item.in_byte;
		keep = (b >= 8'h20 && b <= 8'h7e) || (b >= 8'h09 && b <= 8'h0d);
		if (filter_enable && !keep) begin
			b = CH_SPACE;
		end
		bp = (b == CH_PLUS) ? CH_SPACE : b;
		hv = hex_val(bp);
		d = 8'd0;
		have = 1'b0;
		have_r0 = 1'b0;
		r0 = '0;
		in_value_n = in_value_q;
		esc_n = esc_q;
		hi_n = hi_q;
		open_n = open_q;
		count_n = count_q;
		dropped = count_q >= limit;

		if (dropped) begin
			r0 = '{kind: KIND_NONE, data_byte: 8'd0, pair_index: count_q,
				bad_escape: 1'b0, overflow: 1'b1, run_last: 1'b0};
			have_r0 = 1'b1;
		end else if (b == CH_AMP) begin
			r0 = '{kind: KIND_END, data_byte: 8'd0, pair_index: count_q,
				bad_escape: (esc_q != ESC_NONE), overflow: 1'b0, run_last: 1'b0};
			have_r0 = 1'b1;
			count_n = count_q + 16'd1;
			in_value_n = 1'b0;
			esc_n = ESC_NONE;
			hi_n = 8'd0;
			open_n = 1'b0;
		end else begin
			open_n = 1'b1;
			unique case (esc_q)
				ESC_HIGH: begin
					hi_n = {hv[3:0], 4'h0};
					esc_n = ESC_LOW;
				end
				ESC_LOW: begin
					d = hi_q + hv;
					esc_n = ESC_NONE;
					hi_n = 8'd0;
					have = 1'b1;
				end
				default: begin
					if (bp == CH_PCT) begin
						esc_n = ESC_HIGH;
					end else begin
						d = bp;
						have = 1'b1;
					end
				end
			endcase
			if (have) begin
				if (!in_value_q && d == CH_EQ) begin
					in_value_n = 1'b1;
				end else begin
					r0 = '{kind: in_value_q ? KIND_VALUE : KIND_NAME, data_byte: d,
						pair_index: count_q, bad_escape: 1'b0, overflow: 1'b0,
						run_last: 1'b0};
					have_r0 = 1'b1;
				end
			end
		end

		// close the open pair at end of buffer
		end_valid = item.in_last && !dropped && open_n;
		r_end = '{kind: KIND_END, data_byte: 8'd0, pair_index: count_n,
			bad_escape: (esc_n != ESC_NONE), overflow: 1'b0, run_last: 1'b1};

		if (item.in_last) begin
			in_value_n = 1'b0;
			esc_n = ESC_NONE;
			hi_n = 8'd0;
			open_n = 1'b0;
			count_n = 16'd0;
		end

		r_none = '{kind: KIND_NONE, data_byte: 8'd0, pair_index: count_n,
			bad_escape: 1'b0, overflow: 1'b0, run_last: 1'b1};

		burst = '0;
		if (have_r0 && end_valid) begin
			burst.count = 2'd2;
			burst.first = r0;
			burst.second = r_end;
		end else if (have_r0) begin
			burst.count = 2'd1;
			burst.first = r0;
			burst.first.run_last = 1'b1;
		end else if (end_valid) begin
			burst.count = 2'd1;
			burst.first = r_end;
		end else begin
			burst.count = 2'd1;
			burst.first = r_none;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_value_q <= 1'b0;
			esc_q <= ESC_NONE;
			hi_q <= 8'd0;
			open_q <= 1'b0;
			count_q <= 16'd0;
		end else if (advance) begin
			in_value_q <= in_value_n;
			esc_q <= esc_n;
			hi_q <= hi_n;
			open_q <= open_n;
			count_q <= count_n;
		end
	end

	a_two_results_end_pair: assert property (@(posedge clk) disable iff (!arst_n)
		burst.count == 2'd2 |-> burst.second.kind == KIND_END && burst.second.run_last
			&& !burst.first.run_last && burst.first.kind != KIND_NONE)
		else $error("second result of a byte is not a closing pair end");

	a_drop_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		burst.first.overflow |-> burst.count == 2'd1 && burst.first.kind == KIND_NONE)
		else $error("dropped byte produced data or a pair end");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.in_last |=> count_q == 16'd0 && esc_q == ESC_NONE && !open_q
			&& !in_value_q)
		else $error("stream state not cleared after end of buffer");

endmodule

>>> hw/rtl/ufq_out_queue.sv
// Three-entry queue that takes a one- or two-result burst and emits one per ready cycle.
module ufq_out_queue import ufq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ufq_burst_t burst,
	output logic       space,
	output logic       out_valid,
	input  logic       out_ready,
	output ufq_out_t   out_data
);

	ufq_out_t   q_q [3];
	ufq_out_t   q_n [3];
	logic [1:0] cnt_q, cnt_n, avail;
	logic       pop;

	assign out_valid = cnt_q != 2'd0;
	assign out_data = q_q[0];
	assign pop = out_valid && out_ready;
	assign avail = cnt_q - {1'b0, pop};
	// room for a full burst once the head transfer is counted
	assign space = avail <= 2'd1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pop && i < 2) begin
				q_n[i] = q_q[i + 1];
			end else begin
				q_n[i] = q_q[i];
			end
			if (push && 2'(i) == avail) begin
				q_n[i] = burst.first;
			end
			if (push && burst.count == 2'd2 && 2'(i) == avail + 2'd1) begin
				q_n[i] = burst.second;
			end
		end
		cnt_n = avail + (push ? burst.count : 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			q_q[i] <= q_n[i];
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> {1'b0, avail} + {1'b0, burst.count} <= 3'd3)
		else $error("result queue overfilled");

	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!push && !pop |=> $stable(cnt_q))
		else $error("queue count moved without a push or a transfer");

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the form query decoder: query bytes in, decoded tokens out.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ufq_pkg::*;

	localparam int HOLD_CYCLES  = 150;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 4;
	localparam int REPORT_LINES = 40;

	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_HIGH = 2'd1;
	localparam logic [1:0] ESC_LOW  = 2'd2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	ufq_in_t     in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	ufq_out_t    out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	url_form_query_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Decoder state as the predictor sees it
	logic        filter_on = 1'b0;
	logic [15:0] pair_max = MAX_PAIRS_RESET;
	logic        in_value_part = 1'b0;
	logic [1:0]  esc_phase = ESC_NONE;
	logic [7:0]  esc_high = '0;
	logic        pair_started = 1'b0;
	logic [15:0] pair_num = '0;

	ufq_out_t    expected_tokens[$];
	logic [7:0]  query_buf[$];

	int err_count = 0;
	int items_sent = 0;
	int tokens_seen = 0;
	int buffers_sent = 0;
	int drops_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	function automatic logic [7:0] digit_weight(input logic [7:0] b);
		if (!b[7] && b >= "A")
			return (b & 8'hdf) - 8'd55;
		return b - 8'd48;
	endfunction

	function automatic logic [15:0] pair_cap();
		return (pair_max < IndexCap) ? pair_max : IndexCap;
	endfunction

	function automatic ufq_out_t make_token(input logic [1:0] kind, input logic [7:0] data,
			input logic bad, input logic ovf);
		ufq_out_t t;
		t.kind = kind;
		t.data_byte = data;
		t.pair_index = pair_num;
		t.bad_escape = bad;
		t.overflow = ovf;
		t.run_last = 1'b0;
		return t;
	endfunction

	function automatic void decode_byte(input ufq_in_t item);
		logic [7:0] b;
		logic [7:0] d;
		logic       have;
		logic       dropped;
		ufq_out_t   burst[$];
		b = item.in_byte;
		d = '0;
		have = 1'b0;
		dropped = 1'b0;
		if (filter_on && !((b >= 8'h20 && b <= 8'h7e) || (b >= 8'h09 && b <= 8'h0d)))
			b = CH_SPACE;
		if (pair_num >= pair_cap()) begin
			burst.push_back(make_token(KIND_NONE, '0, 1'b0, 1'b1));
			dropped = 1'b1;
		end else if (b == CH_AMP) begin
			burst.push_back(make_token(KIND_END, '0, esc_phase != ESC_NONE, 1'b0));
			pair_num = pair_num + 16'd1;
			in_value_part = 1'b0;
			esc_phase = ESC_NONE;
			esc_high = '0;
			pair_started = 1'b0;
		end else begin
			pair_started = 1'b1;
			if (b == CH_PLUS)
				b = CH_SPACE;
			case (esc_phase)
				ESC_HIGH: begin
					esc_high = digit_weight(b) << 4;
					esc_phase = ESC_LOW;
				end
				ESC_LOW: begin
					d = esc_high + digit_weight(b);
					esc_phase = ESC_NONE;
					esc_high = '0;
					have = 1'b1;
				end
				default: begin
					if (b == CH_PCT) begin
						esc_phase = ESC_HIGH;
					end else begin
						d = b;
						have = 1'b1;
					end
				end
			endcase
			// first decoded '=' only switches to the value part
			if (have) begin
				if (!in_value_part && d == CH_EQ)
					in_value_part = 1'b1;
				else
					burst.push_back(make_token(in_value_part ? KIND_VALUE : KIND_NAME, d,
						1'b0, 1'b0));
			end
		end
		if (item.in_last) begin
			if (!dropped && pair_started)
				burst.push_back(make_token(KIND_END, '0, esc_phase != ESC_NONE, 1'b0));
			in_value_part = 1'b0;
			esc_phase = ESC_NONE;
			esc_high = '0;
			pair_started = 1'b0;
			pair_num = '0;
		end
		if (burst.size() == 0)
			burst.push_back(make_token(KIND_NONE, '0, 1'b0, 1'b0));
		burst[burst.size() - 1].run_last = 1'b1;
		foreach (burst[i])
			expected_tokens.push_back(burst[i]);
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		err_count++;
		if (err_count <= REPORT_LINES)
			$display("%0t: token %0d %s: got 0x%0h, expected 0x%0h", $time, tokens_seen, what,
				got, want);
	endtask

	task automatic check_token(input ufq_out_t got);
		ufq_out_t want;
		tokens_seen++;
		if (got.overflow === 1'b1)
			drops_seen++;
		if (expected_tokens.size() == 0) begin
			report_mismatch("arrived with nothing expected, kind", got.kind, KIND_NONE);
			return;
		end
		want = expected_tokens.pop_front();
		if (got.kind !== want.kind)
			report_mismatch("kind", got.kind, want.kind);
		if (got.data_byte !== want.data_byte)
			report_mismatch("data_byte", got.data_byte, want.data_byte);
		if (got.pair_index !== want.pair_index)
			report_mismatch("pair_index", got.pair_index, want.pair_index);
		if (got.bad_escape !== want.bad_escape)
			report_mismatch("bad_escape", got.bad_escape, want.bad_escape);
		if (got.overflow !== want.overflow)
			report_mismatch("overflow", got.overflow, want.overflow);
		if (got.run_last !== want.run_last)
			report_mismatch("run_last", got.run_last, want.run_last);
	endtask

	// Sample every transfer at the edge it happens on
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_token(out_data);
			if (in_valid && in_ready) begin
				decode_byte(in_data);
				items_sent++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FILTER_ENABLE: filter_on = cfg_data[0];
					CFG_MAX_PAIRS:     pair_max = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d tokens outstanding",
				stall_cycles, expected_tokens.size());
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Hold valid across back-to-back bytes; drop it only for an idle gap
	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= ufq_in_t'{in_byte: b, in_last: last};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
		buffers_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers in one held transfer burst; call only while drained
	task automatic set_config(input logic filt, input logic [15:0] maxp);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_FILTER_ENABLE;
		cfg_data <= {15'd0, filt};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_MAX_PAIRS;
		cfg_data <= maxp;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_symbol();
		string word_chars;
		string hex_chars;
		int    sel;
		word_chars = "abcdefxyzKLMNQ0123789_-.~*";
		hex_chars = "0123456789abcdefABCDEF+gZ";
		sel = $urandom_range(99);
		if (sel < 55) begin
			query_buf.push_back(word_chars[$urandom_range(word_chars.len() - 1)]);
		end else if (sel < 63) begin
			query_buf.push_back(CH_PLUS);
		end else if (sel < 78) begin
			query_buf.push_back(CH_PCT);
			query_buf.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
			query_buf.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
		end else if (sel < 83) begin
			// lone percent: cut short when a separator or the end follows
			query_buf.push_back(CH_PCT);
		end else if (sel < 88) begin
			query_buf.push_back(CH_EQ);
		end else begin
			query_buf.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic send_query();
		int pairs;
		int n;
		query_buf.delete();
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(1, 12);
			repeat (n) query_buf.push_back(8'($urandom_range(255)));
		end else begin
			pairs = $urandom_range(1, 6);
			for (int p = 0; p < pairs; p++) begin
				if (p != 0)
					query_buf.push_back(CH_AMP);
				n = $urandom_range(0, 4);
				repeat (n) add_symbol();
				if ($urandom_range(9) < 8) begin
					query_buf.push_back(CH_EQ);
					n = $urandom_range(0, 6);
					repeat (n) add_symbol();
				end
			end
			if ($urandom_range(9) == 0)
				query_buf.push_back(CH_AMP);
		end
		if (query_buf.size() == 0)
			query_buf.push_back(8'($urandom_range(255)));
		foreach (query_buf[i])
			send_byte(query_buf[i], i == query_buf.size() - 1);
		buffers_sent++;
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input logic filt,
			input logic [15:0] maxp, input int count);
		int stop_at;
		wait_drained();
		set_config(filt, maxp);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			send_query();
	endtask

	// Name/value split, second and decoded '=', plus, empty pair, cut escapes
	task automatic test_pair_split();
		set_config(1'b0, MAX_PAIRS_RESET);
		send_text("a=b=%3D+&%2&&x%");
	endtask

	// Zero and all-ones bytes; buffer ending on a separator
	task automatic test_edge_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(CH_AMP, 1'b1);
		buffers_sent++;
	endtask

	// Filter on: control and high bytes turn to space, whitespace stays; loose hex digits
	task automatic test_filter();
		wait_drained();
		set_config(1'b1, MAX_PAIRS_RESET);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h0a, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h1f, 1'b0);
		send_text("%z+");
	endtask

	// Pair limit of one: everything after the first pair of a buffer is dropped
	task automatic test_pair_limit();
		wait_drained();
		set_config(1'b0, 16'd1);
		send_text("a&b&");
		send_text("q=1");
	endtask

	// Hold the output off while bytes keep coming, then pause until all tokens are out
	task automatic test_backpressure();
		wait_drained();
		set_config(1'b0, MAX_PAIRS_RESET);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests++;
		send_text("one=1&two=%32&three=a+b+c&four=%34%34&x=");
		wait_drained();
	endtask

	task automatic test_random_traffic();
		run_phase(25, 62, 1'b0, MAX_PAIRS_RESET, 260);
		run_phase(25, 62, 1'b1, 16'd3, 260);
		run_phase(62, 25, 1'b0, 16'd1, 250);
		run_phase(62, 25, 1'b1, 16'hffff, 250);
		run_phase(0, 0, 1'b0, 16'($urandom_range(2, 6)), 250);
		run_phase(0, 0, 1'b1, 16'd2, 250);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pair_split();
		test_edge_bytes();
		test_filter();
		test_pair_limit();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		$display("ran %0d query bytes in %0d buffers, checked %0d tokens (%0d dropped bytes)",
			items_sent, buffers_sent, tokens_seen, drops_seen);
		$display("filter off and on, pair limits 1 to 65535, idling both ways, %0d output hold-offs",
			hold_requests);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
